### rtl/wwfs_pkg.sv
// shared types, widths and codes for the window weighted frequency sum block
`timescale 1ns / 1ps

package wwfs_pkg;

    localparam int ARRAY_DEPTH_DEF = 4096;
    localparam int VALUE_BITS_DEF  = 16;

    localparam int INDEX_BITS    = 12;
    localparam int VALUE_IN_BITS = 16;
    localparam int POS_BITS      = 13;
    localparam int CNT_BITS      = 13;
    localparam int SUM_BITS      = 41;
    localparam int SUM_OUT_BITS  = 40;
    localparam int STATUS_BITS   = 2;

    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    localparam logic [STATUS_BITS-1:0] STATUS_LOAD   = 2'd0;
    localparam logic [STATUS_BITS-1:0] STATUS_ANSWER = 2'd1;
    localparam logic [STATUS_BITS-1:0] STATUS_REJECT = 2'd2;

    typedef struct packed {
        logic                     opcode;
        logic [INDEX_BITS-1:0]    index;
        logic [VALUE_IN_BITS-1:0] value;
        logic [POS_BITS-1:0]      left;
        logic [POS_BITS-1:0]      right;
    } wwfs_cmd_t;

    typedef struct packed {
        logic [SUM_OUT_BITS-1:0] window_sum_out;
        logic [STATUS_BITS-1:0]  status;
    } wwfs_result_t;

    // control for the shared multiply-accumulate unit
    typedef struct packed {
        logic mul_en;
        logic shrink;
    } wwfs_mac_ctl_t;

endpackage

### rtl/wwfs_ram.sv
// single write port, single read port memory with registered read data
`timescale 1ns / 1ps

module wwfs_ram #(
    parameter int DEPTH = 4096,
    parameter int WIDTH = 16,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### rtl/wwfs_mac.sv
// shared multiply-accumulate unit: (2c +/- 1) * v into the running window sum
`timescale 1ns / 1ps

module wwfs_mac #(
    parameter int VALUE_BITS = wwfs_pkg::VALUE_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  wwfs_pkg::wwfs_mac_ctl_t       ctl,
    input  logic [wwfs_pkg::CNT_BITS-1:0] cnt,
    input  logic [VALUE_BITS-1:0]         val,
    output logic [wwfs_pkg::SUM_BITS-1:0] sum
);
    import wwfs_pkg::*;

    localparam int FW = CNT_BITS + 1;
    localparam int PW = FW + VALUE_BITS;

    logic [FW-1:0]       factor;
    logic [PW-1:0]       prod_next;
    logic [PW-1:0]       prod_reg;
    logic                acc_en_reg;
    logic                shrink_reg;
    logic [SUM_BITS-1:0] sum_reg;
    logic [SUM_BITS-1:0] sum_next;

    // count delta of the squared term: 2c+1 on growth, 2c-1 on removal
    always_comb
    begin
        if (ctl.shrink)
        begin
            factor = {cnt, 1'b0} - FW'(1);
        end
        else
        begin
            factor = {cnt, 1'b0} + FW'(1);
        end
        prod_next = PW'(factor) * PW'(val);
    end

    always_comb
    begin
        if (shrink_reg)
        begin
            sum_next = sum_reg - SUM_BITS'(prod_reg);
        end
        else
        begin
            sum_next = sum_reg + SUM_BITS'(prod_reg);
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.mul_en)
        begin
            prod_reg <= prod_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_en_reg <= 1'b0;
            shrink_reg <= 1'b0;
            sum_reg    <= '0;
        end
        else
        begin
            acc_en_reg <= ctl.mul_en;
            if (ctl.mul_en)
            begin
                shrink_reg <= ctl.shrink;
            end
            if (acc_en_reg)
            begin
                sum_reg <= sum_next;
            end
        end
    end

    assign sum = sum_reg;

endmodule

### rtl/window_weighted_frequency_sum.sv
// top level: sequencer walking the window ends over the element store and count table
`timescale 1ns / 1ps

// a load or a rejected item gives its result strobe in the cycle after the transfer
// a query walks the window ends one element step at a time through pick, fetch and update, then strobes from done;
//   steps = |lo - left| + |hi - right| against the window the previous query left behind
// each step over an element is a store read, a count read and a multiply, serialized through one mac unit
// one item at a time: a query keeps busy high until its result is issued; loads and rejects never raise busy
// reset: clearing pass over the element store and the count table, busy high; no stall on output
module window_weighted_frequency_sum #(
    parameter int ARRAY_DEPTH = wwfs_pkg::ARRAY_DEPTH_DEF,
    parameter int VALUE_BITS  = wwfs_pkg::VALUE_BITS_DEF
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    output logic                   busy,
    input  wwfs_pkg::wwfs_cmd_t    cmd,
    output logic                   done,
    output wwfs_pkg::wwfs_result_t result
);
    import wwfs_pkg::*;

    localparam int AW         = $clog2(ARRAY_DEPTH);
    localparam int CNT_DEPTH  = 1 << VALUE_BITS;
    localparam int CLR_DEPTH  = (ARRAY_DEPTH > CNT_DEPTH) ? ARRAY_DEPTH : CNT_DEPTH;
    localparam int CW         = $clog2(CLR_DEPTH);

    // sequencer states
    localparam logic [2:0] S_CLEAR  = 3'd0;
    localparam logic [2:0] S_IDLE   = 3'd1;
    localparam logic [2:0] S_PICK   = 3'd2;
    localparam logic [2:0] S_FETCH  = 3'd3;
    localparam logic [2:0] S_UPDATE = 3'd4;
    localparam logic [2:0] S_DONE   = 3'd5;

    logic [2:0]            state_reg;
    logic [2:0]            state_next;
    logic [CW-1:0]         clr_cnt_reg;
    logic [POS_BITS-1:0]   lo_reg;
    logic [POS_BITS-1:0]   lo_next;
    logic [POS_BITS-1:0]   hi_reg;
    logic [POS_BITS-1:0]   hi_next;
    logic [POS_BITS-1:0]   left_reg;
    logic [POS_BITS-1:0]   right_reg;
    logic                  shrink_reg;
    logic                  shrink_next;
    logic [VALUE_BITS-1:0] val_reg;
    logic                  done_reg;
    logic                  done_next;
    wwfs_result_t          result_reg;
    wwfs_result_t          result_next;

    // item decode in idle
    logic                  accept;
    logic                  load_ok;
    logic                  query_ok;

    // step selection in pick
    logic                  grow_lo;
    logic                  grow_hi;
    logic                  shr_lo;
    logic                  shr_hi;
    logic                  step_go;
    logic [POS_BITS-1:0]   pos_sel;

    // memory ports
    logic                  clr_in_store;
    logic                  clr_in_cnt;
    logic                  st_we;
    logic [AW-1:0]         st_waddr;
    logic [VALUE_BITS-1:0] st_wdata;
    logic                  st_re;
    logic [AW-1:0]         st_raddr;
    logic [VALUE_BITS-1:0] st_rdata;
    logic                  ct_we;
    logic [VALUE_BITS-1:0] ct_waddr;
    logic [CNT_BITS-1:0]   ct_wdata;
    logic                  ct_re;
    logic [CNT_BITS-1:0]   ct_rdata;
    logic                  cnt_zero_skip;

    wwfs_mac_ctl_t         mac_ctl;
    logic [SUM_BITS-1:0]   mac_sum;

    assign accept   = start && (state_reg == S_IDLE);
    // a load may not touch an element inside the live window
    assign load_ok  = (32'(cmd.index) < 32'(ARRAY_DEPTH))
                      && !(({1'b0, cmd.index} >= lo_reg) && ({1'b0, cmd.index} < hi_reg));
    assign query_ok = (cmd.left <= cmd.right) && (32'(cmd.right) <= 32'(ARRAY_DEPTH));

    // expanding steps first so no count ever underflows
    assign grow_lo = lo_reg > left_reg;
    assign grow_hi = hi_reg < right_reg;
    assign shr_lo  = lo_reg < left_reg;
    assign shr_hi  = hi_reg > right_reg;

    always_comb
    begin
        lo_next     = lo_reg;
        hi_next     = hi_reg;
        pos_sel     = lo_reg;
        shrink_next = 1'b0;
        step_go     = 1'b0;
        if (grow_lo)
        begin
            lo_next = lo_reg - POS_BITS'(1);
            pos_sel = lo_reg - POS_BITS'(1);
            step_go = 1'b1;
        end
        else if (grow_hi)
        begin
            hi_next = hi_reg + POS_BITS'(1);
            pos_sel = hi_reg;
            step_go = 1'b1;
        end
        else if (shr_lo)
        begin
            lo_next     = lo_reg + POS_BITS'(1);
            pos_sel     = lo_reg;
            shrink_next = 1'b1;
            step_go     = lo_reg < hi_reg;
        end
        else if (shr_hi)
        begin
            hi_next     = hi_reg - POS_BITS'(1);
            pos_sel     = hi_reg - POS_BITS'(1);
            shrink_next = 1'b1;
            step_go     = (hi_reg - POS_BITS'(1)) >= left_reg;
        end
    end

    // removal of a value whose count is already zero leaves the count and the sum alone
    assign cnt_zero_skip = shrink_reg && (ct_rdata == '0);

    always_comb
    begin
        state_next  = state_reg;
        done_next   = 1'b0;
        result_next = result_reg;
        unique case (state_reg)
            S_CLEAR:
            begin
                if (clr_cnt_reg == CW'(CLR_DEPTH - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    result_next.window_sum_out = '0;
                    result_next.status         = STATUS_REJECT;
                    if (cmd.opcode == OP_LOAD)
                    begin
                        done_next = 1'b1;
                        if (load_ok)
                        begin
                            result_next.status = STATUS_LOAD;
                        end
                    end
                    else if (!query_ok)
                    begin
                        done_next = 1'b1;
                    end
                    else
                    begin
                        state_next = S_PICK;
                    end
                end
            end
            S_PICK:
            begin
                if (step_go)
                begin
                    state_next = S_FETCH;
                end
                else if (!(grow_lo || grow_hi || shr_lo || shr_hi))
                begin
                    state_next = S_DONE;
                end
            end
            S_FETCH:
            begin
                state_next = S_UPDATE;
            end
            S_UPDATE:
            begin
                state_next = S_PICK;
            end
            S_DONE:
            begin
                // last accumulate landed at the end of pick
                done_next                  = 1'b1;
                result_next.window_sum_out = mac_sum[SUM_OUT_BITS-1:0];
                result_next.status         = STATUS_ANSWER;
                state_next                 = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_CLEAR;
            clr_cnt_reg <= '0;
            lo_reg      <= '0;
            hi_reg      <= '0;
            done_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
            if (state_reg == S_CLEAR)
            begin
                clr_cnt_reg <= clr_cnt_reg + CW'(1);
            end
            if (state_reg == S_PICK)
            begin
                lo_reg <= lo_next;
                hi_reg <= hi_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
        if (accept)
        begin
            left_reg  <= cmd.left;
            right_reg <= cmd.right;
        end
        if (state_reg == S_PICK)
        begin
            shrink_reg <= shrink_next;
        end
        if (state_reg == S_FETCH)
        begin
            val_reg <= st_rdata;
        end
    end

    // memory port muxing: clearing pass after reset, loads in idle, walk reads and count updates
    assign clr_in_store = 32'(clr_cnt_reg) < 32'(ARRAY_DEPTH);
    assign clr_in_cnt   = 32'(clr_cnt_reg) < 32'(CNT_DEPTH);

    always_comb
    begin
        if (state_reg == S_CLEAR)
        begin
            st_we    = clr_in_store;
            st_waddr = AW'(clr_cnt_reg);
            st_wdata = '0;
            ct_we    = clr_in_cnt;
            ct_waddr = VALUE_BITS'(clr_cnt_reg);
            ct_wdata = '0;
        end
        else
        begin
            st_we    = accept && (cmd.opcode == OP_LOAD) && load_ok;
            st_waddr = AW'(cmd.index);
            st_wdata = VALUE_BITS'(cmd.value);
            ct_we    = (state_reg == S_UPDATE) && !cnt_zero_skip;
            ct_waddr = val_reg;
            ct_wdata = shrink_reg ? (ct_rdata - CNT_BITS'(1)) : (ct_rdata + CNT_BITS'(1));
        end
    end

    assign st_re    = (state_reg == S_PICK) && step_go;
    assign st_raddr = AW'(pos_sel);
    assign ct_re    = state_reg == S_FETCH;

    assign mac_ctl.mul_en = (state_reg == S_UPDATE) && !cnt_zero_skip;
    assign mac_ctl.shrink = shrink_reg;

    wwfs_ram #(
        .DEPTH (ARRAY_DEPTH),
        .WIDTH (VALUE_BITS)
    ) u_store (
        .clk   (clk),
        .we    (st_we),
        .waddr (st_waddr),
        .wdata (st_wdata),
        .re    (st_re),
        .raddr (st_raddr),
        .rdata (st_rdata)
    );

    wwfs_ram #(
        .DEPTH (CNT_DEPTH),
        .WIDTH (CNT_BITS)
    ) u_count (
        .clk   (clk),
        .we    (ct_we),
        .waddr (ct_waddr),
        .wdata (ct_wdata),
        .re    (ct_re),
        .raddr (st_rdata),
        .rdata (ct_rdata)
    );

    wwfs_mac #(
        .VALUE_BITS (VALUE_BITS)
    ) u_mac (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (mac_ctl),
        .cnt   (ct_rdata),
        .val   (val_reg),
        .sum   (mac_sum)
    );

    assign busy   = state_reg != S_IDLE;
    assign done   = done_reg;
    assign result = result_reg;

    // window stays ordered and inside the store
    a_window_order: assert property (@(posedge clk) disable iff (!rst_n)
        lo_reg <= hi_reg)
        else $error("window start passed window end");

    a_window_bound: assert property (@(posedge clk) disable iff (!rst_n)
        32'(hi_reg) <= 32'(ARRAY_DEPTH))
        else $error("window end beyond store");

    // counts stay consistent with the window contents
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_UPDATE && shrink_reg) |-> (ct_rdata != '0))
        else $error("removal from a value with zero count");

    // a load's result strobe follows in the next cycle with the block free again
    a_load_result: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && cmd.opcode == OP_LOAD) |=> (done && !busy))
        else $error("load transfer without its result strobe");

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (state_reg == S_IDLE))
        else $error("result strobe while sequencer active");

endmodule

### verif/window_weighted_frequency_sum_test.sv
// testbench for the window weighted frequency sum block: directed and random traffic
`timescale 1ns / 1ps

module window_weighted_frequency_sum_test;

    import wwfs_pkg::*;

    localparam int STORE_DEPTH = ARRAY_DEPTH_DEF;
    localparam int RANDOM_ITEMS = 1080;
    localparam int IDLE_PCT = 11;

    logic         clk = 1'b0;
    logic         rst_n = 1'b0;
    logic         start = 1'b0;
    logic         busy;
    wwfs_cmd_t    cmd = '0;
    logic         done;
    wwfs_result_t result;

    window_weighted_frequency_sum uut (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .cmd    (cmd),
        .done   (done),
        .result (result)
    );

    always #6 clk = ~clk;

    // shadow of the block state, advanced once per accepted command
    logic [VALUE_IN_BITS-1:0] elem_mem [0:STORE_DEPTH-1];
    int unsigned              value_count [0:(1 << VALUE_BITS_DEF)-1];
    int unsigned              win_lo;
    int unsigned              win_hi;
    logic [SUM_BITS-1:0]      win_sum;

    // results still owed by the block, oldest first
    wwfs_result_t expected_results[$];

    int  errors = 0;
    bit  gaps_on = 1'b1;
    int  loads_done = 0;
    int  queries_answered = 0;
    int  items_rejected = 0;
    longint unsigned element_steps = 0;
    logic [SUM_OUT_BITS-1:0] widest_sum = '0;

    // element enters the window: (c+1)^2 v - c^2 v = (2c+1) v
    function automatic void add_elem(input int unsigned pos);
        logic [VALUE_IN_BITS-1:0] v;
        longint unsigned c;
        v = elem_mem[pos % STORE_DEPTH];
        c = 64'(value_count[v]);
        win_sum = SUM_BITS'(win_sum + (2 * c + 1) * v);
        value_count[v] = 32'(c + 1);
        element_steps++;
    endfunction

    // element leaves the window: c^2 v - (c-1)^2 v = (2c-1) v
    function automatic void drop_elem(input int unsigned pos);
        logic [VALUE_IN_BITS-1:0] v;
        longint unsigned c;
        v = elem_mem[pos % STORE_DEPTH];
        c = 64'(value_count[v]);
        element_steps++;
        if (c == 0)
            return;
        win_sum = SUM_BITS'(win_sum - (2 * c - 1) * v);
        value_count[v] = 32'(c - 1);
    endfunction

    // expected result of one command, updating the shadow state
    function automatic wwfs_result_t predict_cmd(input wwfs_cmd_t c);
        wwfs_result_t r;
        r.window_sum_out = '0;
        r.status = STATUS_REJECT;
        if (c.opcode == OP_LOAD) begin
            // index is 12 bits wide, so only the inside-window case can reject
            if (c.index >= win_lo && c.index < win_hi)
                return r;
            elem_mem[c.index] = c.value;
            r.status = STATUS_LOAD;
            return r;
        end
        if (c.left > c.right || c.right > STORE_DEPTH)
            return r;
        // grow both ends first so no count goes below zero
        while (win_lo > c.left) begin
            win_lo--;
            add_elem(win_lo);
        end
        while (win_hi < c.right) begin
            add_elem(win_hi);
            win_hi++;
        end
        while (win_lo < c.left) begin
            if (win_lo < win_hi)
                drop_elem(win_lo);
            win_lo++;
        end
        while (win_hi > c.right) begin
            win_hi--;
            if (win_hi >= c.left)
                drop_elem(win_hi);
        end
        r.window_sum_out = win_sum[SUM_OUT_BITS-1:0];
        r.status = STATUS_ANSWER;
        return r;
    endfunction

    function automatic wwfs_cmd_t make_load(input int idx, input int val);
        wwfs_cmd_t c;
        c.opcode = OP_LOAD;
        c.index  = INDEX_BITS'(idx);
        c.value  = VALUE_IN_BITS'(val);
        // query fields are don't-care on a load, fill them with noise
        c.left   = POS_BITS'($urandom_range(8191));
        c.right  = POS_BITS'($urandom_range(8191));
        return c;
    endfunction

    function automatic wwfs_cmd_t make_query(input int l, input int r);
        wwfs_cmd_t c;
        c.opcode = OP_QUERY;
        c.index  = INDEX_BITS'($urandom_range(4095));
        c.value  = VALUE_IN_BITS'($urandom_range(65535));
        c.left   = POS_BITS'(l);
        c.right  = POS_BITS'(r);
        return c;
    endfunction

    // one command transfer; start stays high across back-to-back transfers
    task automatic send_cmd(input wwfs_cmd_t c);
        wwfs_result_t r;
        while (gaps_on && $urandom_range(99) < IDLE_PCT) begin
            start <= 1'b0;
            @(posedge clk);
        end
        start <= 1'b1;
        cmd   <= c;
        @(posedge clk);
        // busy read here is the value seen by this edge
        while (busy)
            @(posedge clk);
        r = predict_cmd(c);
        expected_results.push_back(r);
        case (r.status)
            STATUS_LOAD:   loads_done++;
            STATUS_ANSWER: queries_answered++;
            default:       items_rejected++;
        endcase
        if (r.window_sum_out > widest_sum)
            widest_sum = r.window_sum_out;
    endtask

    // sender holds off until the block has answered everything
    task automatic drain_results();
        start <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
    endtask

    // result strobe lasts one cycle and cannot be stalled
    always @(posedge clk)
    begin : result_check
        wwfs_result_t want;
        if (rst_n && done) begin
            if (expected_results.size() == 0) begin
                $display("%0t: result with nothing pending: sum %0d status %0d",
                         $time, result.window_sum_out, result.status);
                errors++;
            end else begin
                want = expected_results.pop_front();
                if (result.window_sum_out !== want.window_sum_out) begin
                    $display("%0t: window_sum_out expected %0d actual %0d",
                             $time, want.window_sum_out, result.window_sum_out);
                    errors++;
                end
                if (result.status !== want.status) begin
                    $display("%0t: status expected %0d actual %0d",
                             $time, want.status, result.status);
                    errors++;
                end
            end
        end
    end

    // empty window straight after the clearing pass
    task automatic test_empty_after_reset();
        send_cmd(make_query(0, 0));
    endtask

    // loads with repeated values, a query over them, loads at and inside the edges
    task automatic test_loads_and_inside_rejects();
        send_cmd(make_load(0, 16'hFFFF));
        send_cmd(make_load(1, 16'h0000));
        send_cmd(make_load(2, 16'hFFFF));
        send_cmd(make_load(3, 16'h0001));
        send_cmd(make_load(4, 16'hFFFF));
        send_cmd(make_load(4095, 16'hFFFF));
        send_cmd(make_query(0, 5));
        // inside [0,5): store must stay unchanged
        send_cmd(make_load(2, 16'h1234));
        // just past the window end is legal
        send_cmd(make_load(5, 16'hAAAA));
        send_cmd(make_load(12'h555, 16'h5555));
    endtask

    // reversed windows and windows past the end of the store
    task automatic test_malformed_queries();
        send_cmd(make_query(7, 3));
        send_cmd(make_query(0, STORE_DEPTH + 1));
        send_cmd(make_query(8191, 8191));
        send_cmd(make_query(STORE_DEPTH + 1, STORE_DEPTH));
    endtask

    // full sweeps: empty at the far end, whole store, one element, back to empty
    task automatic test_window_extremes();
        send_cmd(make_query(STORE_DEPTH, STORE_DEPTH));
        send_cmd(make_query(0, STORE_DEPTH));
        // window covers everything, so any load is rejected
        send_cmd(make_load(100, 16'h00FF));
        send_cmd(make_query(STORE_DEPTH - 1, STORE_DEPTH));
        send_cmd(make_query(3, 3));
    endtask

    // mostly loads near the window and small window moves, some noise and long sweeps
    task automatic test_random_traffic();
        int sent;
        int pick;
        int idx;
        int val;
        int l;
        int r;
        int t;
        int value_pool [8];
        value_pool = '{0, 1, 3, 16'h7FFF, 16'h8000, 16'h1234, 16'hFFFE, 16'hFFFF};
        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            // stretch with no sender gaps at all
            gaps_on = !(sent >= 250 && sent < 450);
            if (sent == 600)
                drain_results();
            pick = $urandom_range(99);
            if (pick < 35) begin
                // small value pool so counts climb above one
                if ($urandom_range(99) < 70)
                    val = value_pool[$urandom_range(7)];
                else
                    val = $urandom_range(65535);
                if ($urandom_range(99) < 80 && (win_lo > 0 || win_hi < STORE_DEPTH)) begin
                    if (win_lo > 0 && (win_hi >= STORE_DEPTH || $urandom_range(1) == 1)) begin
                        t = (win_lo - 1 < 63) ? win_lo - 1 : 63;
                        idx = win_lo - 1 - $urandom_range(t);
                    end else begin
                        t = (STORE_DEPTH - 1 - win_hi < 63) ? STORE_DEPTH - 1 - win_hi : 63;
                        idx = win_hi + $urandom_range(t);
                    end
                end else begin
                    idx = $urandom_range(STORE_DEPTH - 1);
                end
                send_cmd(make_load(idx, val));
            end else if (pick < 90) begin
                // local move of both ends, the common well-formed case
                l = int'(win_lo) + $urandom_range(48) - 24;
                r = int'(win_hi) + $urandom_range(48) - 24;
                l = (l < 0) ? 0 : (l > STORE_DEPTH) ? STORE_DEPTH : l;
                r = (r < 0) ? 0 : (r > STORE_DEPTH) ? STORE_DEPTH : r;
                if (l > r) begin
                    t = l;
                    l = r;
                    r = t;
                end
                send_cmd(make_query(l, r));
            end else if (pick < 93) begin
                // long sweep to a fresh random window
                l = $urandom_range(STORE_DEPTH);
                r = $urandom_range(STORE_DEPTH, l);
                send_cmd(make_query(l, r));
            end else if (pick < 97) begin
                r = $urandom_range(8190);
                l = $urandom_range(8191, r + 1);
                send_cmd(make_query(l, r));
            end else begin
                r = $urandom_range(8191, STORE_DEPTH + 1);
                l = $urandom_range(r);
                send_cmd(make_query(l, r));
            end
            sent++;
        end
        gaps_on = 1'b1;
    endtask

    initial begin
        foreach (elem_mem[i])
            elem_mem[i] = '0;
        foreach (value_count[i])
            value_count[i] = 0;
        win_lo  = 0;
        win_hi  = 0;
        win_sum = '0;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // the clearing pass after reset is absorbed by the busy handshake
        test_empty_after_reset();
        test_loads_and_inside_rejects();
        drain_results();
        test_malformed_queries();
        test_window_extremes();
        drain_results();
        test_random_traffic();

        drain_results();
        // load and reject strobes come in the cycle after their transfer; leave room for strays
        repeat (20) @(posedge clk);

        $display("covered %0d loads, %0d answered queries, %0d rejected items",
                 loads_done, queries_answered, items_rejected);
        $display("window walked %0d element steps, largest sum reported %0d",
                 element_steps, widest_sum);
        if (errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    // generous bound: clearing pass, full sweeps and the random part several times over
    initial begin
        #100_000_000;
        $display("timeout with %0d results outstanding", expected_results.size());
        $display("FAILURE");
        $finish;
    end

endmodule
